// ===== hdl/cima_pkg.sv =====
// Package for the central image moment accumulator: widths, register indexes, states.
`timescale 1ns / 1ps
`default_nettype none
package cima_pkg;

    localparam int PATCH_DIM = 32;

    localparam int VALUE_W  = 16;
    localparam int COORD_W  = 5;
    localparam int EXP_W    = 3;
    localparam int CENTRE_W = 13;
    localparam int SUM_W    = 64;
    localparam int WIDE_W   = 128;
    localparam int CHUNK_W  = 32;
    localparam int IDX_W    = 4;
    localparam int TDATA_IN_W = 32;

    localparam logic [EXP_W-1:0] EXP_MAX = 3'd4;
    localparam logic [EXP_W-1:0] EXP_RESET = 3'd2;
    localparam logic [CENTRE_W-1:0] CENTRE_RESET = 13'd4096;

    localparam logic [SUM_W-1:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_MIN = 64'h8000_0000_0000_0000;

    localparam logic [IDX_W-1:0] REG_EXP_ROW    = 4'd0;
    localparam logic [IDX_W-1:0] REG_EXP_COL    = 4'd1;
    localparam logic [IDX_W-1:0] REG_CENTRE_ROW = 4'd2;
    localparam logic [IDX_W-1:0] REG_CENTRE_COL = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROUND,
        ST_SHIFT,
        ST_TERM,
        ST_ACC
    } state_t;

endpackage
`default_nettype wire

// ===== hdl/central_image_moment_accumulator.sv =====
// Central moment mu_pq accumulator with one shared 32x13 multiplier under a sequencer.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: value, row, col; s_tlast: last pixel
//  m_      | out | m_tvalid/m_tready  | m_tdata: moment_sum; m_tuser: saturated
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A request is loaded, then each offset factor is applied in the shared 32x13
// multiplier (one 32-bit chunk of the 128-bit product per cycle), then round,
// shift, clamp and accumulate. s_tready is high only when idle.
// Synchronous active-low reset restores register defaults and clears the sum.
// A last-pixel request waits in the accumulate step while the output register is full and m_tready is low.
`timescale 1ns / 1ps
`default_nettype none
module central_image_moment_accumulator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] pixel_value, [20:16] pixel_row, [25:21] pixel_col
    input  wire logic        s_tlast,   // last_pixel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] moment_sum
    output logic             m_tuser,   // [0] saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);

    cima_pkg::state_t state_reg, state_next;

    logic [2:0]   exp_row_reg, exp_col_reg;
    logic [12:0]  centre_row_reg, centre_col_reg;

    logic [127:0] m_reg, m_next;
    logic [12:0]  carry_reg, carry_next;
    logic [1:0]   chunk_reg, chunk_next;
    logic [2:0]   rem_row_reg, rem_row_next;
    logic [2:0]   rem_col_reg, rem_col_next;
    logic [6:0]   fbits_reg, fbits_next;
    logic [12:0]  mr_reg, mr_next, mc_reg, mc_next;
    logic         neg_reg, neg_next;
    logic         last_reg, last_next;
    logic [63:0]  mag_reg, mag_next;
    logic         big_reg, big_next;
    logic [63:0]  term_reg, term_next;
    logic [63:0]  sum_reg, sum_next;
    logic         ovf_reg, ovf_next;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  out_sum_reg, out_sum_next;
    logic         out_sat_reg, out_sat_next;

    // input decode
    logic [15:0] in_value;
    logic [4:0]  in_row, in_col;
    logic [2:0]  p_clamp, q_clamp;
    logic [13:0] dr, dc;
    logic [12:0] mr_in, mc_in;

    assign in_value = s_tdata[15:0];
    assign in_row   = s_tdata[20:16];
    assign in_col   = s_tdata[25:21];
    assign p_clamp  = (exp_row_reg > cima_pkg::EXP_MAX) ? cima_pkg::EXP_MAX : exp_row_reg;
    assign q_clamp  = (exp_col_reg > cima_pkg::EXP_MAX) ? cima_pkg::EXP_MAX : exp_col_reg;
    assign dr = {1'b0, in_row, 8'd0} - {1'b0, centre_row_reg};
    assign dc = {1'b0, in_col, 8'd0} - {1'b0, centre_col_reg};
    assign mr_in = dr[13] ? 13'(-dr) : dr[12:0];
    assign mc_in = dc[13] ? 13'(-dc) : dc[12:0];

    // shared multiplier
    logic [12:0] factor;
    logic [45:0] prod;
    assign factor = (rem_row_reg != 3'd0) ? mr_reg : mc_reg;
    assign prod = 46'(m_reg[31:0]) * 46'(factor) + 46'(carry_reg);

    // rounding and shifting
    logic [5:0]   rshift;
    logic [63:0]  half;
    logic [64:0]  lo_sum;
    logic [127:0] shifted;
    logic         frac_ge16;
    assign frac_ge16 = (fbits_reg >= 7'd16);
    assign rshift = 6'(fbits_reg - 7'd16);
    assign half = (frac_ge16 && rshift != 6'd0) ? (64'd1 << (rshift - 6'd1)) : 64'd0;
    assign lo_sum = {1'b0, m_reg[63:0]} + {1'b0, half};
    assign shifted = m_reg >> rshift;

    // saturating accumulate
    logic [63:0] acc_raw;
    logic        acc_ovf;
    assign acc_raw = sum_reg + term_reg;
    assign acc_ovf = (sum_reg[63] == term_reg[63]) && (acc_raw[63] != sum_reg[63]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cima_pkg::ST_IDLE;
            exp_row_reg    <= cima_pkg::EXP_RESET;
            exp_col_reg    <= cima_pkg::EXP_RESET;
            centre_row_reg <= cima_pkg::CENTRE_RESET;
            centre_col_reg <= cima_pkg::CENTRE_RESET;
            sum_reg        <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            rem_row_reg    <= '0;
            rem_col_reg    <= '0;
            chunk_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            rem_row_reg   <= rem_row_next;
            rem_col_reg   <= rem_col_next;
            chunk_reg     <= chunk_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    cima_pkg::REG_EXP_ROW:    exp_row_reg    <= cfg_data[2:0];
                    cima_pkg::REG_EXP_COL:    exp_col_reg    <= cfg_data[2:0];
                    cima_pkg::REG_CENTRE_ROW: centre_row_reg <= cfg_data;
                    cima_pkg::REG_CENTRE_COL: centre_col_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_reg       <= m_next;
        carry_reg   <= carry_next;
        fbits_reg   <= fbits_next;
        mr_reg      <= mr_next;
        mc_reg      <= mc_next;
        neg_reg     <= neg_next;
        last_reg    <= last_next;
        mag_reg     <= mag_next;
        big_reg     <= big_next;
        term_reg    <= term_next;
        out_sum_reg <= out_sum_next;
        out_sat_reg <= out_sat_next;
    end

    always_comb begin
        state_next     = state_reg;
        m_next         = m_reg;
        carry_next     = carry_reg;
        chunk_next     = chunk_reg;
        rem_row_next   = rem_row_reg;
        rem_col_next   = rem_col_reg;
        fbits_next     = fbits_reg;
        mr_next        = mr_reg;
        mc_next        = mc_reg;
        neg_next       = neg_reg;
        last_next      = last_reg;
        mag_next       = mag_reg;
        big_next       = big_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;
        out_sat_next   = out_sat_reg;
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            cima_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    m_next       = {112'd0, in_value};
                    carry_next   = '0;
                    chunk_next   = '0;
                    rem_row_next = p_clamp;
                    rem_col_next = q_clamp;
                    fbits_next   = {{1'b0, p_clamp} + {1'b0, q_clamp}, 3'd0};
                    mr_next      = mr_in;
                    mc_next      = mc_in;
                    neg_next     = (dr[13] && p_clamp[0]) != (dc[13] && q_clamp[0]);
                    last_next    = s_tlast;
                    state_next   = (p_clamp == 3'd0 && q_clamp == 3'd0) ?
                                   cima_pkg::ST_ROUND : cima_pkg::ST_MUL;
                end
            end
            cima_pkg::ST_MUL: begin
                m_next     = {prod[31:0], m_reg[127:32]};
                carry_next = prod[44:32];
                chunk_next = chunk_reg + 2'd1;
                if (chunk_reg == 2'd3) begin
                    carry_next = '0;
                    if (rem_row_reg != 3'd0) begin
                        rem_row_next = rem_row_reg - 3'd1;
                    end else begin
                        rem_col_next = rem_col_reg - 3'd1;
                    end
                    if ((rem_row_reg == 3'd1 && rem_col_reg == 3'd0) ||
                        (rem_row_reg == 3'd0 && rem_col_reg == 3'd1)) begin
                        state_next = cima_pkg::ST_ROUND;
                    end
                end
            end
            cima_pkg::ST_ROUND: begin
                m_next     = {m_reg[127:64] + 64'(lo_sum[64]), lo_sum[63:0]};
                state_next = cima_pkg::ST_SHIFT;
            end
            cima_pkg::ST_SHIFT: begin
                if (frac_ge16) begin
                    mag_next = shifted[63:0];
                    big_next = (shifted[127:64] != 64'd0);
                end else begin
                    mag_next = m_reg[63:0] << (7'd16 - fbits_reg);
                    big_next = 1'b0;
                end
                state_next = cima_pkg::ST_TERM;
            end
            cima_pkg::ST_TERM: begin
                if (neg_reg) begin
                    if (big_reg || mag_reg > cima_pkg::SUM_MIN) begin
                        term_next = cima_pkg::SUM_MIN;
                        ovf_next  = 1'b1;
                    end else begin
                        term_next = 64'd0 - mag_reg;
                    end
                end else begin
                    if (big_reg || mag_reg[63]) begin
                        term_next = cima_pkg::SUM_MAX;
                        ovf_next  = 1'b1;
                    end else begin
                        term_next = mag_reg;
                    end
                end
                state_next = cima_pkg::ST_ACC;
            end
            cima_pkg::ST_ACC: begin
                if (!last_reg) begin
                    sum_next   = acc_ovf ? (sum_reg[63] ? cima_pkg::SUM_MIN : cima_pkg::SUM_MAX)
                                         : acc_raw;
                    ovf_next   = ovf_reg || acc_ovf;
                    state_next = cima_pkg::ST_IDLE;
                end else if (!out_valid_reg || m_tready) begin
                    out_sum_next   = acc_ovf ? (sum_reg[63] ? cima_pkg::SUM_MIN
                                                            : cima_pkg::SUM_MAX) : acc_raw;
                    out_sat_next   = ovf_reg || acc_ovf;
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = cima_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cima_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_sum_reg;
    assign m_tuser   = out_sat_reg;
    assign cfg_ready = 1'b1;

    a_result_from_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == cima_pkg::ST_ACC) && $past(last_reg))
        else $error("result appeared without a last-pixel accumulate");

    a_mul_has_factor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cima_pkg::ST_MUL) |-> (rem_row_reg != 3'd0 || rem_col_reg != 3'd0))
        else $error("multiply step with no factor left");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one is in flight");

    a_sum_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg == cima_pkg::ST_ACC) && $past(last_reg) &&
         state_reg == cima_pkg::ST_IDLE) |-> (sum_reg == 64'd0 && !ovf_reg))
        else $error("sum not cleared after patch end");

endmodule
`default_nettype wire

// ===== bench/central_image_moment_accumulator_tb.sv =====
// Self-checking bench for the moment accumulator: directed corner patches, then random raster patches.
`timescale 1ns / 1ps
module central_image_moment_accumulator_tb;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] pixel_value, [20:16] pixel_row, [25:21] pixel_col
    logic        s_tlast;   // last_pixel
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] moment_sum
    logic        m_tuser;   // [0] saturated
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [12:0] cfg_data;

    typedef struct packed {
        logic [cima_pkg::SUM_W-1:0] moment;
        logic                       sat;
    } moment_t;

    moment_t expected_moments[$];

    // shadow copy of the block's registers and accumulator
    logic [cima_pkg::EXP_W-1:0]    shadow_exp_row;
    logic [cima_pkg::EXP_W-1:0]    shadow_exp_col;
    logic [cima_pkg::CENTRE_W-1:0] shadow_centre_row;
    logic [cima_pkg::CENTRE_W-1:0] shadow_centre_col;
    logic [cima_pkg::SUM_W-1:0]    shadow_total;
    logic                          shadow_sat;

    int mismatch_count = 0;
    int pixels_sent = 0;
    bit no_gaps = 1'b0;

    central_image_moment_accumulator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Adds one pixel's (row-xc)^p * (col-yc)^q * value term to the shadow sum.
    function automatic void accumulate_pixel(input logic [cima_pkg::VALUE_W-1:0] value,
                                             input logic [cima_pkg::COORD_W-1:0] row,
                                             input logic [cima_pkg::COORD_W-1:0] col,
                                             input logic last);
        logic [cima_pkg::EXP_W-1:0]    p;
        logic [cima_pkg::EXP_W-1:0]    q;
        int                            dr;
        int                            dc;
        int                            k;
        int                            fb;
        int                            sh;
        logic [cima_pkg::CENTRE_W-1:0] mr;
        logic [cima_pkg::CENTRE_W-1:0] mc;
        logic [cima_pkg::WIDE_W-1:0]   prod;
        logic [cima_pkg::SUM_W-1:0]    mag;
        logic [cima_pkg::SUM_W-1:0]    term;
        logic [cima_pkg::SUM_W-1:0]    next_total;
        logic                          neg;
        logic                          big;
        moment_t                       entry;
        p  = (shadow_exp_row > cima_pkg::EXP_MAX) ? cima_pkg::EXP_MAX : shadow_exp_row;
        q  = (shadow_exp_col > cima_pkg::EXP_MAX) ? cima_pkg::EXP_MAX : shadow_exp_col;
        dr = int'(row) * 256 - int'(shadow_centre_row);
        dc = int'(col) * 256 - int'(shadow_centre_col);
        mr = cima_pkg::CENTRE_W'((dr < 0) ? -dr : dr);
        mc = cima_pkg::CENTRE_W'((dc < 0) ? -dc : dc);
        neg = ((dr < 0) && p[0]) != ((dc < 0) && q[0]);
        prod = cima_pkg::WIDE_W'(value);
        for (k = 0; k < p; k++) prod = prod * mr;
        for (k = 0; k < q; k++) prod = prod * mc;
        fb  = 8 * (int'(p) + int'(q));
        big = 1'b0;
        if (fb >= 16) begin
            sh = fb - 16;
            if (sh > 0) prod = (prod + (128'd1 << (sh - 1))) >> sh;
            big = |prod[cima_pkg::WIDE_W-1:cima_pkg::SUM_W];
            mag = prod[cima_pkg::SUM_W-1:0];
        end else begin
            mag = prod[cima_pkg::SUM_W-1:0] << (16 - fb);
        end
        if (neg) begin
            if (big || mag > cima_pkg::SUM_MIN) begin
                big  = 1'b1;
                term = cima_pkg::SUM_MIN;
            end else begin
                term = -mag;
            end
        end else begin
            if (big || mag > cima_pkg::SUM_MAX) begin
                big  = 1'b1;
                term = cima_pkg::SUM_MAX;
            end else begin
                term = mag;
            end
        end
        if (big) shadow_sat = 1'b1;
        next_total = shadow_total + term;
        if (shadow_total[cima_pkg::SUM_W-1] == term[cima_pkg::SUM_W-1] &&
            next_total[cima_pkg::SUM_W-1] != shadow_total[cima_pkg::SUM_W-1]) begin
            shadow_sat = 1'b1;
            next_total = shadow_total[cima_pkg::SUM_W-1] ? cima_pkg::SUM_MIN
                                                         : cima_pkg::SUM_MAX;
        end
        shadow_total = next_total;
        if (last) begin
            entry.moment = shadow_total;
            entry.sat    = shadow_sat;
            expected_moments = {expected_moments, entry};
            shadow_total = '0;
            shadow_sat   = 1'b0;
        end
    endfunction

    function automatic logic [cima_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return cima_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [cima_pkg::CENTRE_W-1:0] pick_centre();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return cima_pkg::CENTRE_W'($urandom_range(0, cima_pkg::PATCH_DIM - 1) * 256);
            default: return cima_pkg::CENTRE_W'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_pixel(input logic [cima_pkg::VALUE_W-1:0] value,
                              input logic [cima_pkg::COORD_W-1:0] row,
                              input logic [cima_pkg::COORD_W-1:0] col, input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, col, row, value};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        accumulate_pixel(value, row, col, last);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [cima_pkg::IDX_W-1:0] idx,
                             input logic [cima_pkg::CENTRE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            cima_pkg::REG_EXP_ROW:    shadow_exp_row    = data[cima_pkg::EXP_W-1:0];
            cima_pkg::REG_EXP_COL:    shadow_exp_col    = data[cima_pkg::EXP_W-1:0];
            cima_pkg::REG_CENTRE_ROW: shadow_centre_row = data;
            cima_pkg::REG_CENTRE_COL: shadow_centre_col = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [cima_pkg::CENTRE_W-1:0] p,
                              input logic [cima_pkg::CENTRE_W-1:0] q,
                              input logic [cima_pkg::CENTRE_W-1:0] xc,
                              input logic [cima_pkg::CENTRE_W-1:0] yc);
        write_reg(cima_pkg::REG_EXP_ROW, p);
        write_reg(cima_pkg::REG_EXP_COL, q);
        write_reg(cima_pkg::REG_CENTRE_ROW, xc);
        write_reg(cima_pkg::REG_CENTRE_COL, yc);
    endtask

    // Drains outstanding results, then lets a pixel with no result finish.
    task automatic settle();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_moments.size() != 0 && guard < 5000) begin
            @(negedge aclk);
            guard++;
        end
        if (expected_moments.size() != 0) begin
            report_mismatch("result never arrived", '0, expected_moments[0].moment);
            expected_moments.delete();
        end
        repeat (50) @(negedge aclk);
    endtask

    // Raster scan of a rectangle; now and then the closing flag is dropped.
    task automatic send_patch();
        int nr;
        int nc;
        int r0;
        int c0;
        int r;
        int c;
        bit broken;
        case ($urandom_range(0, 19))
            0: begin nr = cima_pkg::PATCH_DIM; nc = 2; end
            1: begin nr = 2; nc = cima_pkg::PATCH_DIM; end
            default: begin nr = $urandom_range(1, 6); nc = $urandom_range(1, 6); end
        endcase
        r0 = $urandom_range(0, cima_pkg::PATCH_DIM - nr);
        c0 = $urandom_range(0, cima_pkg::PATCH_DIM - nc);
        broken = ($urandom_range(0, 9) == 0);
        for (r = 0; r < nr; r++) begin
            for (c = 0; c < nc; c++) begin
                send_pixel(pick_value(), cima_pkg::COORD_W'(r0 + r),
                           cima_pkg::COORD_W'(c0 + c),
                           (r == nr - 1) && (c == nc - 1) && !broken);
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_pixel(16'h0000, 5'd0, 5'd0, 1'b0);
        send_pixel(16'hFFFF, 5'd31, 5'd31, 1'b0);
        send_pixel(16'd12345, 5'd16, 5'd3, 1'b1);   // row on centre, zero term
        settle();
    endtask

    task automatic test_zero_powers();
        set_config(13'd0, 13'd0, 13'd4096, 13'd4096);
        send_pixel(16'd100, 5'd16, 5'd16, 1'b0);    // 0^0 counts as one
        send_pixel(16'hFFFF, 5'd31, 5'd0, 1'b1);
        settle();
    endtask

    task automatic test_odd_powers();
        set_config(13'd1, 13'd3, 13'd0, 13'd8191);
        send_pixel(16'hFFFF, 5'd31, 5'd0, 1'b0);
        send_pixel(16'd777, 5'd0, 5'd31, 1'b0);
        send_pixel(16'hFFFF, 5'd31, 5'd31, 1'b1);
        settle();
    endtask

    task automatic test_exponent_clamp();
        // 7 and 5 behave as 4; upper data bits are not part of the register
        set_config(13'h1FFF, 13'h0025, 13'd8191, 13'd0);
        send_pixel(16'hFFFF, 5'd0, 5'd31, 1'b0);
        send_pixel(16'd1, 5'd5, 5'd5, 1'b0);
        send_pixel(16'd0, 5'd31, 5'd0, 1'b1);
        settle();
    endtask

    task automatic test_saturation();
        set_config(13'd3, 13'd4, 13'd4096, 13'd0);
        send_pixel(16'd20000, 5'd0, 5'd31, 1'b0);
        send_pixel(16'd20000, 5'd0, 5'd31, 1'b0);  // sum clamps low
        send_pixel(16'hFFFF, 5'd0, 5'd31, 1'b0);   // term clamps too
        send_pixel(16'd20000, 5'd31, 5'd31, 1'b1); // climbs back from the clamp
        send_pixel(16'd1, 5'd16, 5'd0, 1'b1);      // flag cleared for next patch
        settle();
    endtask

    task automatic test_unknown_index();
        int idx;
        for (idx = 4; idx < 16; idx++) begin
            write_reg(cima_pkg::IDX_W'(idx), cima_pkg::CENTRE_W'($urandom));
        end
        send_pixel(16'hFFFF, 5'd1, 5'd30, 1'b0);
        send_pixel(16'd3, 5'd30, 5'd1, 1'b1);
        settle();
    endtask

    task automatic test_random_patches();
        int start;
        int k;
        start = pixels_sent;
        while (pixels_sent - start < 2000) begin
            set_config(cima_pkg::CENTRE_W'($urandom), cima_pkg::CENTRE_W'($urandom),
                       pick_centre(), pick_centre());
            if ($urandom_range(0, 7) == 0) begin
                write_reg(cima_pkg::IDX_W'($urandom_range(4, 15)),
                          cima_pkg::CENTRE_W'($urandom));
            end
            no_gaps = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 9) == 0) begin
                    for (k = $urandom_range(1, 4); k > 0; k--) begin
                        send_pixel(pick_value(), cima_pkg::COORD_W'($urandom),
                                   cima_pkg::COORD_W'($urandom),
                                   $urandom_range(0, 3) == 0);
                    end
                end
                send_patch();
            end
            settle();
            no_gaps = 1'b0;
        end
    endtask

    initial begin : drive_ready
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        moment_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_moments.size() == 0) begin
                report_mismatch("result with no request pending", m_tdata, '0);
            end else begin
                want = expected_moments.pop_front();
                if (m_tdata !== want.moment) report_mismatch("moment_sum", m_tdata, want.moment);
                if (m_tuser !== want.sat) report_mismatch("saturated", 64'(m_tuser), 64'(want.sat));
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        shadow_exp_row    = cima_pkg::EXP_RESET;
        shadow_exp_col    = cima_pkg::EXP_RESET;
        shadow_centre_row = cima_pkg::CENTRE_RESET;
        shadow_centre_col = cima_pkg::CENTRE_RESET;
        shadow_total      = '0;
        shadow_sat        = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_zero_powers();
        test_odd_powers();
        test_exponent_clamp();
        test_saturation();
        test_unknown_index();
        test_random_patches();
        settle();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/cima_pkg.sv
hdl/central_image_moment_accumulator.sv
bench/central_image_moment_accumulator_tb.sv
